// File: sv/thumb_alu_with_flags_macros.svh
// Assertion macros for the Thumb ALU block.
// Used by the top level; expects a clock named clock and a reset named reset.
`ifndef THUMB_ALU_WITH_FLAGS_MACROS_SVH
`define THUMB_ALU_WITH_FLAGS_MACROS_SVH
`ifndef SYNTHESIS
`define TAWF_ASSERT_NOW(name, pre, post) \
   name: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error("tawf assertion failed");
`define TAWF_ASSERT_NEXT(name, pre, post) \
   name: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error("tawf assertion failed");
`else
`define TAWF_ASSERT_NOW(name, pre, post)
`define TAWF_ASSERT_NEXT(name, pre, post)
`endif
`endif

// File: sv/tawf_pkg.sv
// Shared types and constants for the Thumb ALU block.
// No dependencies; the interfaces, the ALU and the top level import this package.
package tawf_pkg;

   localparam int NumRegs = 16;
   localparam int RegIdxW = (NumRegs > 1) ? $clog2(NumRegs) : 1;
   localparam int DataW   = 32;
   localparam int IdxW    = 4;
   localparam int ShW     = 5;

   typedef enum logic [2:0] {
      CMD_AND,
      CMD_ADC,
      CMD_ADD,
      CMD_BIC,
      CMD_LSL,
      CMD_ASR,
      CMD_LOAD_REG,
      CMD_LOAD_FLAGS
   } cmd_type;

   typedef struct packed {
      logic n;
      logic z;
      logic c;
      logic v;
   } flags_type;

   typedef struct packed {
      cmd_type          command;
      logic [DataW-1:0] a;
      logic [DataW-1:0] b;
      logic [DataW-1:0] load_value;
      flags_type        flags;
   } alu_in_type;

   typedef struct packed {
      logic [DataW-1:0] value;
      flags_type        flags;
      logic             wr_en;
   } alu_out_type;

endpackage

// File: sv/tawf_ifs.sv
// Valid/ready channel interfaces for request and response words.
// Depends on tawf_pkg for widths.
interface tawf_req_if import tawf_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [2:0]       command;
   logic [IdxW-1:0]  dest_index;
   logic [IdxW-1:0]  src_index;
   logic [DataW-1:0] load_value;

   modport source (output valid, command, dest_index, src_index, load_value, input ready);
   modport sink (input valid, command, dest_index, src_index, load_value, output ready);
endinterface

interface tawf_rsp_if import tawf_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [DataW-1:0] result_value;
   logic             flag_negative;
   logic             flag_zero;
   logic             flag_carry;
   logic             flag_overflow;

   modport source (output valid, result_value, flag_negative, flag_zero, flag_carry,
                   flag_overflow, input ready);
   modport sink (input valid, result_value, flag_negative, flag_zero, flag_carry,
                 flag_overflow, output ready);
endinterface

// File: sv/tawf_alu.sv
// Combinational ALU: and, adc, add, bic, lsl, asr and the two load commands.
// Depends on tawf_pkg.
module tawf_alu import tawf_pkg::*; (
   input  alu_in_type  op_in,
   output alu_out_type op_out
);

   logic [DataW:0]        sum;
   logic [DataW:0]        lsl_wide;
   logic signed [DataW:0] asr_wide;
   logic                  cin;
   logic                  big;
   logic                  alu;
   logic [DataW-1:0]      res;
   flags_type             fl;

   always_comb begin
      cin      = (op_in.command == CMD_ADC) && op_in.flags.c;
      sum      = {1'b0, op_in.a} + {1'b0, op_in.b} + {{DataW{1'b0}}, cin};
      lsl_wide = {1'b0, op_in.a} << op_in.b[ShW-1:0];
      asr_wide = $signed({op_in.a, 1'b0}) >>> op_in.b[ShW-1:0];
      big      = |op_in.b[DataW-1:ShW];
      res      = op_in.a;
      fl       = op_in.flags;
      alu      = 1'b1;
      op_out.wr_en = 1'b1;
      case (op_in.command)
         CMD_AND: res = op_in.a & op_in.b;
         CMD_BIC: res = op_in.a & ~op_in.b;
         CMD_ADC, CMD_ADD: begin
            res  = sum[DataW-1:0];
            fl.c = sum[DataW];
            fl.v = ~(op_in.a[DataW-1] ^ op_in.b[DataW-1]) & (op_in.a[DataW-1] ^ res[DataW-1]);
         end
         CMD_LSL: begin
            if (op_in.b == '0) begin
               res = op_in.a;
            end else if (!big) begin
               res  = lsl_wide[DataW-1:0];
               fl.c = lsl_wide[DataW];
            end else if (op_in.b == DataW'(DataW)) begin
               res  = '0;
               fl.c = op_in.a[0];
            end else begin
               res  = '0;
               fl.c = 1'b0;
            end
         end
         CMD_ASR: begin
            if (op_in.b == '0) begin
               res = op_in.a;
            end else if (big) begin
               res  = {DataW{op_in.a[DataW-1]}};
               fl.c = op_in.a[DataW-1];
            end else begin
               res  = asr_wide[DataW:1];
               fl.c = asr_wide[0];
            end
         end
         CMD_LOAD_REG: begin
            alu = 1'b0;
            res = op_in.load_value;
         end
         CMD_LOAD_FLAGS: begin
            alu          = 1'b0;
            op_out.wr_en = 1'b0;
            fl           = flags_type'(op_in.load_value[3:0]);
         end
         default: res = op_in.a;
      endcase
      if (alu) begin
         fl.n = res[DataW-1];
         fl.z = (res == '0);
      end
      op_out.value = res;
      op_out.flags = fl;
   end

endmodule

// File: sv/thumb_alu_with_flags.sv
// Top level of the Thumb ALU block: register file, flags, operand stage, result word.
// Depends on tawf_pkg, tawf_ifs, tawf_alu and the macros header.
//
// One request word is taken per cycle while request ready is high, and gives exactly
// one response word. A word sits in the operand stage, where the two register file
// reads made at acceptance are used, until the response side can take it, then lands
// in the response register, which drives the response word; the sustained rate is
// one word per cycle as long as the response side keeps ready high. A write to the
// register file by the word ahead is forwarded to the word behind, so dependent
// commands run back to back. The register file and flags read as zero after reset;
// no clearing pass is needed. Request ready is low while reset is high.
`include "thumb_alu_with_flags_macros.svh"

module thumb_alu_with_flags import tawf_pkg::*; (
   input logic        clock,
   input logic        reset,
   tawf_req_if.sink   req_word,
   tawf_rsp_if.source rsp_word
);

   logic [DataW-1:0]   mem_ff [NumRegs];
   logic [NumRegs-1:0] written_ff;

   logic               s1_valid_ff;
   cmd_type            cmd_ff;
   logic [IdxW-1:0]    dest_ff;
   logic [DataW-1:0]   lv_ff;
   logic [DataW-1:0]   rd_a_ff;
   logic [DataW-1:0]   rd_b_ff;
   logic               vld_a_ff;
   logic               vld_b_ff;
   logic               fwd_a_ff;
   logic               fwd_b_ff;
   logic [DataW-1:0]   fwd_data_ff;
   flags_type          flags_ff;

   logic               out_valid_ff;
   logic [DataW-1:0]   out_value_ff;
   flags_type          out_flags_ff;

   logic               accept;
   logic               s1_adv;
   logic               dest_in_range;
   logic               wr_now;
   logic               req_dest_ok;
   logic               req_src_ok;
   logic               ld_flags_adv;
   logic               logic_adv;
   logic [DataW-1:0]   op_a;
   logic [DataW-1:0]   op_b;
   alu_in_type         alu_in;
   alu_out_type        alu_out;

   assign s1_adv         = s1_valid_ff && (!out_valid_ff || rsp_word.ready);
   assign req_word.ready = !reset && (!s1_valid_ff || s1_adv);
   assign accept         = req_word.valid && req_word.ready;
   assign dest_in_range  = int'(dest_ff) < NumRegs;
   assign wr_now         = s1_adv && alu_out.wr_en && dest_in_range;
   assign req_dest_ok    = int'(req_word.dest_index) < NumRegs;
   assign req_src_ok     = int'(req_word.src_index) < NumRegs;
   assign ld_flags_adv   = s1_adv && (cmd_ff == CMD_LOAD_FLAGS);
   assign logic_adv      = s1_adv && (cmd_ff inside {CMD_AND, CMD_BIC});

   assign op_a = fwd_a_ff ? fwd_data_ff : (vld_a_ff ? rd_a_ff : '0);
   assign op_b = fwd_b_ff ? fwd_data_ff : (vld_b_ff ? rd_b_ff : '0);

   always_comb begin
      alu_in.command    = cmd_ff;
      alu_in.a          = op_a;
      alu_in.b          = op_b;
      alu_in.load_value = lv_ff;
      alu_in.flags      = flags_ff;
   end

   tawf_alu u_alu (
      .op_in  (alu_in),
      .op_out (alu_out)
   );

   // register file storage and registered reads
   always_ff @(posedge clock) begin
      if (wr_now) begin
         mem_ff[dest_ff[RegIdxW-1:0]] <= alu_out.value;
      end
      if (accept) begin
         rd_a_ff <= mem_ff[req_word.dest_index[RegIdxW-1:0]];
         rd_b_ff <= mem_ff[req_word.src_index[RegIdxW-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         written_ff   <= '0;
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         flags_ff     <= '0;
      end else begin
         if (wr_now) begin
            written_ff[dest_ff[RegIdxW-1:0]] <= 1'b1;
         end
         if (s1_adv) begin
            flags_ff <= alu_out.flags;
         end
         if (accept) begin
            s1_valid_ff <= 1'b1;
         end else if (s1_adv) begin
            s1_valid_ff <= 1'b0;
         end
         if (s1_adv) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_word.ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   // operand stage payload
   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff      <= cmd_type'(req_word.command);
         dest_ff     <= req_word.dest_index;
         lv_ff       <= req_word.load_value;
         vld_a_ff    <= req_dest_ok && written_ff[req_word.dest_index[RegIdxW-1:0]];
         vld_b_ff    <= req_src_ok && written_ff[req_word.src_index[RegIdxW-1:0]];
         fwd_a_ff    <= wr_now && req_dest_ok && (dest_ff == req_word.dest_index);
         fwd_b_ff    <= wr_now && req_src_ok && (dest_ff == req_word.src_index);
         fwd_data_ff <= alu_out.value;
      end
   end

   // response word
   always_ff @(posedge clock) begin
      if (s1_adv) begin
         out_value_ff <= dest_in_range ? alu_out.value : '0;
         out_flags_ff <= alu_out.flags;
      end
   end

   assign rsp_word.valid         = out_valid_ff;
   assign rsp_word.result_value  = out_value_ff;
   assign rsp_word.flag_negative = out_flags_ff.n;
   assign rsp_word.flag_zero     = out_flags_ff.z;
   assign rsp_word.flag_carry    = out_flags_ff.c;
   assign rsp_word.flag_overflow = out_flags_ff.v;

   `TAWF_ASSERT_NOW(a_no_overrun, accept && s1_valid_ff, s1_adv)
   `TAWF_ASSERT_NEXT(a_load_flags, ld_flags_adv, flags_ff == flags_type'($past(lv_ff[3:0])))
   `TAWF_ASSERT_NEXT(a_logic_keeps_cv, logic_adv, flags_ff[1:0] == $past(flags_ff[1:0]))

endmodule
